@@ design/efma_pkg.sv @@
`timescale 1ns / 1ps

package efma_pkg;

	localparam int NUM_REGS = 3;
	localparam int OFS_W = 28;

	localparam logic [1:0] REG_ZERO_OFS_CH0 = 2'd0;
	localparam logic [1:0] REG_ZERO_OFS_CH1 = 2'd1;
	localparam logic [1:0] REG_ZERO_OFS_CH2 = 2'd2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int CRC_SPAN = 7;

	localparam int IDX_CNT0 = 3;
	localparam int IDX_CNT1 = 4;
	localparam int IDX_CNT2 = 5;
	localparam int IDX_CNT3 = 6;
	localparam int IDX_CRC_LO = 7;
	localparam int IDX_CRC_HI = 8;

	localparam int DEG_PER_TURN = 360;
	localparam logic signed [27:0] HALF_TURN_Q18 = 28'sd47185920;
	localparam logic signed [27:0] FULL_TURN_Q18 = 28'sd94371840;

	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_PW = 3;

	typedef struct packed {
		logic [1:0]  channel;
		logic [47:0] abs_angle;
		logic [15:0] turns;
	} result_t;

	typedef struct packed {
		logic             nempty;
		logic [OUTQ_PW:0] level;
	} outq_stat_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ design/efma_ram.sv @@
`timescale 1ns / 1ps

module efma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/efma_outq.sv @@
`timescale 1ns / 1ps

module efma_outq import efma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  result_t    wdata,
	input  logic       pop,
	output result_t    rdata,
	output outq_stat_t stat
);

	result_t              mem_q [OUTQ_DEPTH];
	logic [OUTQ_PW-1:0]   wr_ptr_q;
	logic [OUTQ_PW-1:0]   rd_ptr_q;
	logic [OUTQ_PW:0]     level_q;
	logic                 do_pop;

	assign do_pop = pop && (level_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign stat.nempty = (level_q != '0);
	assign stat.level = level_q;

endmodule

@@ design/encoder_frame_multiturn_angle.sv @@
`timescale 1ns / 1ps

// Multi-turn angle from several absolute-encoder byte links.
// The s_ channel takes one received byte per request: s_tdata is the byte, s_tuser
// the link number and s_tlast marks the last byte of a frame. A frame of exactly
// FRAME_LEN bytes whose CRC-16 checks produces one result on the m_ channel: m_tuser
// is the link, m_tdata the signed multi-turn angle in Q18 degrees and the turn count.
// Bad frames produce nothing. The cfg_ channel writes the zero offset of links 0 to 2
// and is always ready; the user must write it only while no frame is in progress;
// the block does not enforce this. One byte is accepted per cycle, sustained, while
// s_tready is high. That rate is set by the read-modify-write of the per-link frame
// state memory, with forwarding between requests on the same link. Results pass
// through the pipeline stages into an 8-entry output queue and wait there, so bytes
// keep flowing while the receiver stalls; s_tready drops only when the queued results
// plus frame ends still in the pipeline would fill that queue.
// After reset every link starts a fresh frame, its turn counter is zero, the next good
// frame does no turn check, and all zero offsets are zero.

module encoder_frame_multiturn_angle import efma_pkg::*; #(
	parameter int NUM_CHANNELS = 3,
	parameter int FRAME_LEN = 9,
	parameter int COUNT_BITS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [1:0]  s_tuser,   // channel
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // abs_angle [47:0], turns [63:48]
	output logic [1:0]  m_tuser,   // out_channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [27:0] cfg_data
);

	localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int BC_W = $clog2(FRAME_LEN + 2);
	localparam int PROD_W = COUNT_BITS + 9;
	localparam int ANGLE_W = ((PROD_W > 27) ? PROD_W : 27) + 2;
	localparam int DIFF_W = ANGLE_W + 1;
	localparam int TP_W = 44;
	localparam int FA_W = BC_W + 16 + 32 + 16;
	localparam int AB_W = 1 + 16 + ANGLE_W;
	localparam logic [FA_W-1:0] FA_RESET = {BC_W'(0), CRC_INIT, 32'h0, 16'h0};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic signed [OFS_W-1:0] ofs_q [NUM_REGS];

	logic s_acc;
	logic chan_ok;

	// Frame state memory and forwarding.
	logic [NUM_CHANNELS-1:0] fa_vld_q;
	logic                    fa_we;
	logic [CH_AW-1:0]        fa_waddr;
	logic [CH_AW-1:0]        fa_raddr;
	logic [FA_W-1:0]         fa_wdata;
	logic [FA_W-1:0]         fa_rdata;

	logic            v_s1;
	logic [1:0]      ch_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;
	logic            fwd_s1;
	logic [FA_W-1:0] fwd_data_s1;

	logic [FA_W-1:0] fa_cur;
	logic [BC_W-1:0] bc_cur;
	logic [BC_W-1:0] bc_nxt;
	logic [15:0]     crc_cur;
	logic [15:0]     crc_nxt;
	logic [31:0]     word_cur;
	logic [31:0]     word_nxt;
	logic [15:0]     rx_cur;
	logic [15:0]     rx_nxt;
	logic            good;

	// Angle state memory.
	logic [NUM_CHANNELS-1:0] ab_vld_q;
	logic                    ab_re;
	logic                    ab_we;
	logic [CH_AW-1:0]        ab_waddr;
	logic [AB_W-1:0]         ab_wdata;
	logic [AB_W-1:0]         ab_rdata;

	logic        v_s2;
	logic [1:0]  ch_s2;
	logic [31:0] word_s2;
	logic [COUNT_BITS-1:0]   count_sat;
	logic signed [OFS_W-1:0] ofs_sel;

	logic                    v_s3;
	logic [1:0]              ch_s3;
	logic [PROD_W-1:0]       prod_s3;
	logic signed [OFS_W-1:0] ofs_s3;
	logic [AB_W-1:0]         ab_s3;

	logic                      v_s4;
	logic [1:0]                ch_s4;
	logic signed [ANGLE_W-1:0] angle_s4;
	logic signed [ANGLE_W-1:0] last_s4;
	logic [15:0]               turns_s4;
	logic                      seen_s4;
	logic signed [DIFF_W-1:0]  diff;
	logic [15:0]               turns_nxt;

	logic                      v_s5;
	logic [1:0]                ch_s5;
	logic signed [ANGLE_W-1:0] angle_s5;
	logic [15:0]               turns_s5;

	logic                      v_s6;
	logic [1:0]                ch_s6;
	logic signed [ANGLE_W-1:0] angle_s6;
	logic signed [TP_W-1:0]    tprod_s6;
	logic [15:0]               turns_s6;

	result_t    push_data;
	result_t    head;
	outq_stat_t q_stat;
	logic [2:0] inflight;

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				ofs_q[r] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ZERO_OFS_CH0: ofs_q[0] <= cfg_data;
				REG_ZERO_OFS_CH1: ofs_q[1] <= cfg_data;
				REG_ZERO_OFS_CH2: ofs_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input side and credit check against the output queue.
	assign inflight = 3'($countones({v_s1 & end_s1, v_s2, v_s3, v_s4, v_s5, v_s6}));
	assign s_tready = (5'(q_stat.level) + 5'(inflight)) < 5'(OUTQ_DEPTH);
	assign s_acc = s_tvalid && s_tready;
	assign chan_ok = 32'(s_tuser) < NUM_CHANNELS;

	assign fa_raddr = CH_AW'(s_tuser);
	assign fa_waddr = CH_AW'(ch_s1);
	assign fa_we = v_s1;

	efma_ram #(.WIDTH(FA_W), .DEPTH(NUM_CHANNELS)) u_frame_ram (
		.clk   (clk),
		.we    (fa_we),
		.waddr (fa_waddr),
		.wdata (fa_wdata),
		.re    (s_acc),
		.raddr (fa_raddr),
		.rdata (fa_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			fa_vld_q <= '0;
			ab_vld_q <= '0;
		end else begin
			v_s1 <= s_acc && chan_ok;
			v_s2 <= v_s1 && good;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			if (fa_we) begin
				fa_vld_q[fa_waddr] <= 1'b1;
			end
			if (ab_we) begin
				ab_vld_q[ab_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ch_s1 <= s_tuser;
		byte_s1 <= s_tdata;
		end_s1 <= s_tlast;
		fwd_s1 <= fa_we && (fa_waddr == fa_raddr);
		fwd_data_s1 <= fa_wdata;
	end

	// Stage 1: update of the link's frame state.
	always_comb begin
		fa_cur = fwd_s1 ? fwd_data_s1 : (fa_vld_q[fa_waddr] ? fa_rdata : FA_RESET);
		{bc_cur, crc_cur, word_cur, rx_cur} = fa_cur;
		bc_nxt = bc_cur;
		crc_nxt = crc_cur;
		word_nxt = word_cur;
		rx_nxt = rx_cur;
		if (bc_cur < BC_W'(FRAME_LEN)) begin
			if (bc_cur == BC_W'(IDX_CNT0)) begin
				word_nxt[31:24] = byte_s1;
			end
			if (bc_cur == BC_W'(IDX_CNT1)) begin
				word_nxt[23:16] = byte_s1;
			end
			if (bc_cur == BC_W'(IDX_CNT2)) begin
				word_nxt[15:8] = byte_s1;
			end
			if (bc_cur == BC_W'(IDX_CNT3)) begin
				word_nxt[7:0] = byte_s1;
			end
			if (bc_cur == BC_W'(IDX_CRC_LO)) begin
				rx_nxt[7:0] = byte_s1;
			end
			if (bc_cur == BC_W'(IDX_CRC_HI)) begin
				rx_nxt[15:8] = byte_s1;
			end
			if (bc_cur < BC_W'(CRC_SPAN)) begin
				crc_nxt = crc16_byte(crc_cur, byte_s1);
			end
		end
		if (bc_cur <= BC_W'(FRAME_LEN)) begin
			bc_nxt = bc_cur + 1'b1;
		end
		good = end_s1 && (bc_nxt == BC_W'(FRAME_LEN)) && (crc_nxt == rx_nxt);
		if (end_s1) begin
			fa_wdata = {BC_W'(0), CRC_INIT, word_nxt, rx_nxt};
		end else begin
			fa_wdata = {bc_nxt, crc_nxt, word_nxt, rx_nxt};
		end
	end

	assign ab_re = v_s1 && good;

	efma_ram #(.WIDTH(AB_W), .DEPTH(NUM_CHANNELS)) u_angle_ram (
		.clk   (clk),
		.we    (ab_we),
		.waddr (ab_waddr),
		.wdata (ab_wdata),
		.re    (ab_re),
		.raddr (fa_waddr),
		.rdata (ab_rdata)
	);

	// Stage 2: saturate the count, scale it to Q18 degrees and select the link's zero offset.
	always_comb begin
		count_sat = (word_s2[31:COUNT_BITS] != '0) ? COUNT_MAX : word_s2[COUNT_BITS-1:0];
		ofs_sel = '0;
		for (int r = 0; r < NUM_REGS; r++) begin
			if (32'(ch_s2) == r) begin
				ofs_sel = ofs_q[r];
			end
		end
	end

	// Stage 4: unwrap against the last angle of the link.
	always_comb begin
		diff = DIFF_W'(angle_s4) - DIFF_W'(last_s4);
		turns_nxt = turns_s4;
		if (seen_s4) begin
			if (diff > DIFF_W'(HALF_TURN_Q18)) begin
				turns_nxt = turns_s4 - 16'd1;
			end else if (diff < -DIFF_W'(HALF_TURN_Q18)) begin
				turns_nxt = turns_s4 + 16'd1;
			end
		end
	end

	assign ab_we = v_s4;
	assign ab_waddr = CH_AW'(ch_s4);
	assign ab_wdata = {1'b1, turns_nxt, angle_s4};

	always_ff @(posedge clk) begin
		ch_s2 <= ch_s1;
		word_s2 <= word_nxt;

		ch_s3 <= ch_s2;
		prod_s3 <= PROD_W'(count_sat) * PROD_W'(DEG_PER_TURN);
		ofs_s3 <= ofs_sel;
		ab_s3 <= ab_vld_q[CH_AW'(ch_s2)] ? ab_rdata : '0;

		ch_s4 <= ch_s3;
		angle_s4 <= ANGLE_W'(ofs_s3) - $signed(ANGLE_W'(prod_s3));
		last_s4 <= ab_s3[ANGLE_W-1:0];
		turns_s4 <= ab_s3[ANGLE_W+15:ANGLE_W];
		seen_s4 <= ab_s3[AB_W-1];

		ch_s5 <= ch_s4;
		angle_s5 <= angle_s4;
		turns_s5 <= turns_nxt;

		ch_s6 <= ch_s5;
		angle_s6 <= angle_s5;
		tprod_s6 <= $signed(turns_s5) * FULL_TURN_Q18;
		turns_s6 <= turns_s5;
	end

	// Stage 6: total angle into the output queue.
	assign push_data.channel = ch_s6;
	assign push_data.abs_angle = 48'(angle_s6) + 48'(tprod_s6);
	assign push_data.turns = turns_s6;

	efma_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s6),
		.wdata  (push_data),
		.pop    (m_tready),
		.rdata  (head),
		.stat   (q_stat)
	);

	assign m_tvalid = q_stat.nempty;
	assign m_tdata = {head.turns, head.abs_angle};
	assign m_tuser = head.channel;

endmodule

@@ bench/encoder_frame_multiturn_angle_tb.sv @@
`timescale 1ns / 1ps

module encoder_frame_multiturn_angle_tb;
	import efma_pkg::*;

	localparam int NUM_CH = 3;
	localparam int FRAME_LEN = 9;
	localparam int COUNT_BITS = 18;
	localparam int MAX_COUNT = (1 << COUNT_BITS) - 1;
	localparam int HALF_COUNTS = 1 << (COUNT_BITS - 1);
	localparam logic [1:0] CH_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam longint OFS_LIMIT = 64'sd94371840;
	localparam int SETTLE_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [1:0] ch;
		logic [7:0] data;
		logic       last;
	} link_byte_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [27:0] cfg_data;

	encoder_frame_multiturn_angle u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the per-link frame, angle and offset state.
	logic [7:0]  frm [NUM_CH][FRAME_LEN];
	int unsigned nbytes [NUM_CH];
	logic [15:0] crc_acc [NUM_CH];
	longint      prev_angle [NUM_CH];
	logic [15:0] turn_cnt [NUM_CH];
	bit          seen [NUM_CH];
	longint      zero_ofs [NUM_CH];

	result_t     angle_q [$];
	link_byte_t  feed_q [$];
	link_byte_t  lane_q [4][$];
	logic [7:0]  frame_buf [$];
	int          walk_pos [NUM_CH];

	int pushed_cnt, accepted_cnt, sent_cnt, lane_items;
	int good_frames, bad_frames, checked_cnt, cfg_writes, err_cnt, idle_cycles;
	int burst_left, gap_left, rdy_left;
	bit in_taken, drain_hold;
	rx_mode_t rdy_mode;
	link_byte_t cur;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic decode_byte(input logic [1:0] ch, input logic [7:0] b, input logic last);
		int c;
		logic [31:0] raw;
		longint count, ang, diff;
		longint half_turn = HALF_TURN_Q18;
		longint full_turn = FULL_TURN_Q18;
		bit ok;
		result_t r;
		if (ch >= NUM_CH)
			return;
		c = ch;
		if (nbytes[c] < FRAME_LEN) begin
			frm[c][nbytes[c]] = b;
			if (nbytes[c] < CRC_SPAN)
				crc_acc[c] = crc_step(crc_acc[c], b);
		end
		if (nbytes[c] <= FRAME_LEN)
			nbytes[c]++;
		if (!last)
			return;
		ok = (nbytes[c] == FRAME_LEN) &&
			(crc_acc[c] == {frm[c][IDX_CRC_HI], frm[c][IDX_CRC_LO]});
		nbytes[c] = 0;
		crc_acc[c] = CRC_INIT;
		if (!ok) begin
			bad_frames++;
			return;
		end
		good_frames++;
		raw = {frm[c][IDX_CNT0], frm[c][IDX_CNT1], frm[c][IDX_CNT2], frm[c][IDX_CNT3]};
		count = raw;
		if (count > MAX_COUNT)
			count = MAX_COUNT;
		ang = zero_ofs[c] - count * DEG_PER_TURN;
		if (seen[c]) begin
			diff = ang - prev_angle[c];
			if (diff > half_turn)
				turn_cnt[c] = turn_cnt[c] - 16'd1;
			if (diff < -half_turn)
				turn_cnt[c] = turn_cnt[c] + 16'd1;
		end
		seen[c] = 1'b1;
		prev_angle[c] = ang;
		r.channel = ch;
		r.abs_angle = 48'(ang + longint'($signed(turn_cnt[c])) * full_turn);
		r.turns = turn_cnt[c];
		angle_q.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (angle_q.size() == 0) begin
					flag_error($sformatf("unexpected result ch %0d angle %0d turns %0d",
						m_tuser, $signed(m_tdata[47:0]), $signed(m_tdata[63:48])));
				end else begin
					result_t e;
					e = angle_q.pop_front();
					checked_cnt++;
					if (m_tuser !== e.channel || m_tdata[47:0] !== e.abs_angle ||
						m_tdata[63:48] !== e.turns)
						flag_error($sformatf({"expected ch %0d angle %0d turns %0d, ",
							"got ch %0d angle %0d turns %0d"},
							e.channel, $signed(e.abs_angle), $signed(e.turns),
							m_tuser, $signed(m_tdata[47:0]), $signed(m_tdata[63:48])));
				end
			end
			if (s_tvalid && s_tready) begin
				in_taken = 1'b1;
				accepted_cnt++;
				decode_byte(s_tuser, s_tdata, s_tlast);
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", idle_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			in_taken = 1'b0;
			if (drain_hold) begin
				if (angle_q.size() == 0)
					drain_hold = 1'b0;
				s_tvalid <= 1'b0;
			end else if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (feed_q.size() != 0) begin
				cur = feed_q.pop_front();
				s_tdata <= cur.data;
				s_tuser <= cur.ch;
				s_tlast <= cur.last;
				s_tvalid <= 1'b1;
				sent_cnt++;
				if (sent_cnt % 400 == 200)
					drain_hold = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 4) == 0) ? 300 : $urandom_range(1, 60);
					gap_left = $urandom_range(1, 10);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rdy_left <= 0) begin
			rdy_mode = rx_mode_t'($urandom_range(0, 3));
			rdy_left = $urandom_range(20, 200);
		end
		rdy_left--;
		case (rdy_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= (rdy_left % 5 >= 2);
		endcase
	end

	task automatic build_good(input logic [31:0] count);
		logic [15:0] crc;
		frame_buf.delete();
		repeat (3) frame_buf.push_back(8'($urandom));
		for (int i = 24; i >= 0; i -= 8)
			frame_buf.push_back(count[i +: 8]);
		crc = CRC_INIT;
		foreach (frame_buf[i])
			crc = crc_step(crc, frame_buf[i]);
		frame_buf.push_back(crc[7:0]);
		frame_buf.push_back(crc[15:8]);
	endtask

	task automatic queue_frame(input logic [1:0] ch);
		link_byte_t b;
		foreach (frame_buf[i]) begin
			b.ch = ch;
			b.data = frame_buf[i];
			b.last = (i == frame_buf.size() - 1);
			lane_q[ch].push_back(b);
		end
		if (ch != CH_UNUSED)
			lane_items += frame_buf.size();
	endtask

	// Position walk per link: small steps, half-turn jumps, jumps right at the
	// half-turn threshold, random positions, range ends and over-range counts.
	task automatic next_count(input int c, output logic [31:0] cnt);
		int unsigned pick;
		int step;
		pick = $urandom_range(0, 99);
		step = 0;
		if (pick < 40) begin
			step = int'($urandom_range(0, 10000)) - 5000;
			walk_pos[c] = (walk_pos[c] + step) & MAX_COUNT;
		end else if (pick < 65) begin
			step = int'($urandom_range(100000, 160000));
			if ($urandom_range(0, 1))
				step = -step;
			walk_pos[c] = (walk_pos[c] + step) & MAX_COUNT;
		end else if (pick < 77) begin
			step = HALF_COUNTS + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1))
				step = -step;
			if (walk_pos[c] + step >= 0 && walk_pos[c] + step <= MAX_COUNT)
				walk_pos[c] = walk_pos[c] + step;
			else if (walk_pos[c] - step >= 0 && walk_pos[c] - step <= MAX_COUNT)
				walk_pos[c] = walk_pos[c] - step;
			else
				walk_pos[c] = (walk_pos[c] + step) & MAX_COUNT;
		end else if (pick < 87) begin
			walk_pos[c] = $urandom_range(0, MAX_COUNT);
		end else if (pick < 93) begin
			walk_pos[c] = $urandom_range(0, 1) ? MAX_COUNT : 0;
		end else begin
			cnt = $urandom | (32'd1 << $urandom_range(COUNT_BITS, 31));
			walk_pos[c] = MAX_COUNT;
			return;
		end
		cnt = walk_pos[c];
	endtask

	task automatic add_random_frame();
		int unsigned pick;
		int len;
		logic [1:0] ch;
		logic [31:0] cnt;
		ch = 2'($urandom_range(0, NUM_CH - 1));
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			next_count(ch, cnt);
			build_good(cnt);
		end else if (pick < 80) begin
			build_good($urandom);
			len = $urandom_range(0, FRAME_LEN - 1);
			frame_buf[len] = frame_buf[len] ^ 8'($urandom_range(1, 255));
		end else if (pick < 87) begin
			build_good($urandom);
			len = $urandom_range(1, FRAME_LEN - 1);
			while (frame_buf.size() > len)
				void'(frame_buf.pop_back());
		end else if (pick < 94) begin
			build_good($urandom_range(0, MAX_COUNT));
			repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom));
		end else begin
			ch = CH_UNUSED;
			frame_buf.delete();
			repeat ($urandom_range(1, FRAME_LEN)) frame_buf.push_back(8'($urandom));
		end
		queue_frame(ch);
	endtask

	task automatic merge_lanes();
		int ch;
		while (lane_q[0].size() + lane_q[1].size() + lane_q[2].size() + lane_q[3].size() != 0)
		begin
			ch = $urandom_range(0, 3);
			if (lane_q[ch].size() != 0) begin
				feed_q.push_back(lane_q[ch].pop_front());
				pushed_cnt++;
			end
		end
	endtask

	task automatic wait_drain();
		do @(negedge clk);
		while (accepted_cnt != pushed_cnt || angle_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(input int n_items);
		lane_items = 0;
		while (lane_items < n_items)
			add_random_frame();
		merge_lanes();
		wait_drain();
	endtask

	task automatic write_offset(input logic [1:0] idx, input longint val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[OFS_W-1:0];
		do @(posedge clk);
		while (!cfg_ready);
		if (idx != REG_UNUSED)
			zero_ofs[idx] = longint'($signed(val[OFS_W-1:0]));
		cfg_writes++;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic longint rand_offset();
		return longint'($urandom_range(0, 2 * 94371840)) - OFS_LIMIT;
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 20;
		for (int c = 0; c < NUM_CH; c++) begin
			nbytes[c] = 0;
			crc_acc[c] = CRC_INIT;
			prev_angle[c] = 0;
			turn_cnt[c] = '0;
			seen[c] = 1'b0;
			zero_ofs[c] = 0;
			walk_pos[c] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		build_good(32'd0);
		queue_frame(2'd0);
		build_good(32'(MAX_COUNT));
		queue_frame(2'd1);
		build_good(32'(MAX_COUNT + 1));
		queue_frame(2'd2);
		frame_buf.delete();
		frame_buf.push_back(8'hFF);
		queue_frame(CH_UNUSED);
		merge_lanes();
		run_random(350);

		write_offset(REG_ZERO_OFS_CH0, OFS_LIMIT);
		write_offset(REG_ZERO_OFS_CH1, -OFS_LIMIT);
		write_offset(REG_ZERO_OFS_CH2, 0);
		write_offset(REG_UNUSED, longint'($urandom));
		end_writes();
		run_random(450);

		write_offset(REG_ZERO_OFS_CH0, rand_offset());
		write_offset(REG_ZERO_OFS_CH1, rand_offset());
		write_offset(REG_ZERO_OFS_CH2, rand_offset());
		end_writes();
		run_random(450);

		write_offset(REG_ZERO_OFS_CH0, -OFS_LIMIT);
		write_offset(REG_ZERO_OFS_CH1, OFS_LIMIT);
		write_offset(REG_ZERO_OFS_CH2, OFS_LIMIT);
		end_writes();
		run_random(450);

		write_offset(REG_ZERO_OFS_CH2, -OFS_LIMIT);
		write_offset(REG_ZERO_OFS_CH0, rand_offset());
		end_writes();
		run_random(150);

		$display("Run covered %0d link bytes, %0d good frames and %0d dropped frames,",
			accepted_cnt, good_frames, bad_frames);
		$display("with %0d angle results checked across %0d offset register writes.",
			checked_cnt, cfg_writes);
		if (err_cnt == 0 && angle_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
